// ===== src/touch_calibrate_debounce_filter_assert.svh =====
// assertion macros shared by the touch filter rtl
`ifndef TOUCH_CALIBRATE_DEBOUNCE_FILTER_ASSERT_SVH
`define TOUCH_CALIBRATE_DEBOUNCE_FILTER_ASSERT_SVH

// property checked on every rising clk edge, held off while rst is high
`define TCDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define TCDF_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== src/tcdf_pkg.sv =====
// types and constants of the touch calibration and debounce filter
package tcdf_pkg;

  localparam int COORD_W    = 16;
  localparam int TOP_W      = 13;
  localparam int TIME_W     = 32;
  localparam int PROD_W     = 29;
  localparam int SQ_W       = 32;
  localparam int AXIS_CNT_W = 5;
  localparam int SQ_CNT_W   = 4;

  typedef enum logic [2:0] {
    REG_DISPLAY_WIDTH  = 3'd0,
    REG_DISPLAY_HEIGHT = 3'd1,
    REG_RAW_X_MIN      = 3'd2,
    REG_RAW_X_MAX      = 3'd3,
    REG_RAW_Y_MIN      = 3'd4,
    REG_RAW_Y_MAX      = 3'd5,
    REG_ORIENTATION    = 3'd6,
    REG_DRAG_THRESHOLD = 3'd7
  } reg_idx_t;

  // per-axis calibration: raw range and top of the calibrated range
  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic [TOP_W-1:0]   top;
  } axis_cfg_t;

endpackage

// ===== src/tcdf_axis.sv =====
// bit-serial linear map of one raw axis: multiply by top, divide by raw span, clamp
module tcdf_axis
  import tcdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] raw,
  input  axis_cfg_t          cfg,
  output logic               done,
  output logic [TOP_W-1:0]   value
);

  typedef enum logic [1:0] {
    P_IDLE,
    P_MUL,
    P_DIV
  } phase_t;

  phase_t                phase;
  logic [AXIS_CNT_W-1:0] cnt;
  logic [COORD_W-1:0]    mag_a;
  logic [COORD_W-1:0]    den;
  logic [TOP_W-1:0]      mult;
  logic [TOP_W-1:0]      top;
  logic [PROD_W-1:0]     acc;
  logic [COORD_W-1:0]    rem;
  logic                  neg;

  logic [COORD_W:0]      diff;
  logic [COORD_W:0]      span;
  logic [COORD_W:0]      shifted;
  logic                  ge;
  logic [COORD_W:0]      rem_sub;
  logic [PROD_W-1:0]     q_next;

  always_comb begin
    diff    = {raw[COORD_W-1], raw} - {cfg.lo[COORD_W-1], cfg.lo};
    span    = {cfg.hi[COORD_W-1], cfg.hi} - {cfg.lo[COORD_W-1], cfg.lo};
    shifted = {rem, acc[PROD_W-1]};
    ge      = shifted >= {1'b0, den};
    rem_sub = shifted - {1'b0, den};
    q_next  = {acc[PROD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == P_DIV) && (cnt == '0);
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            mag_a <= diff[COORD_W] ? COORD_W'(~diff + 1'b1) : diff[COORD_W-1:0];
            den   <= span[COORD_W] ? COORD_W'(~span + 1'b1) : span[COORD_W-1:0];
            neg   <= diff[COORD_W] ^ span[COORD_W];
            mult  <= cfg.top;
            top   <= cfg.top;
            acc   <= '0;
            cnt   <= AXIS_CNT_W'(TOP_W - 1);
            phase <= P_MUL;
          end
        end
        P_MUL: begin
          // msb first shift-add, one multiplier bit a cycle
          acc  <= {acc[PROD_W-2:0], 1'b0}
                  + (mult[TOP_W-1] ? PROD_W'(mag_a) : PROD_W'(0));
          mult <= {mult[TOP_W-2:0], 1'b0};
          if (cnt == '0) begin
            rem   <= '0;
            cnt   <= AXIS_CNT_W'(PROD_W - 1);
            phase <= P_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        P_DIV: begin
          // restoring division, quotient bits shift in behind the dividend
          rem <= ge ? rem_sub[COORD_W-1:0] : shifted[COORD_W-1:0];
          acc <= q_next;
          if (cnt == '0) begin
            phase <= P_IDLE;
            // a negative quotient always clamps to zero
            if (neg) begin
              value <= '0;
            end else if (q_next > PROD_W'(top)) begin
              value <= top;
            end else begin
              value <= q_next[TOP_W-1:0];
            end
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

// ===== src/tcdf_sq.sv =====
// bit-serial square of a signed coordinate difference
module tcdf_sq
  import tcdf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [COORD_W:0] diff,
  output logic             done,
  output logic [SQ_W-1:0]  sq
);

  logic                busy;
  logic [SQ_CNT_W-1:0] cnt;
  logic [COORD_W-1:0]  mag;
  logic [COORD_W-1:0]  mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (!busy) begin
        if (start) begin
          mag  <= diff[COORD_W] ? COORD_W'(~diff + 1'b1) : diff[COORD_W-1:0];
          mult <= diff[COORD_W] ? COORD_W'(~diff + 1'b1) : diff[COORD_W-1:0];
          sq   <= '0;
          cnt  <= SQ_CNT_W'(COORD_W - 1);
          busy <= 1'b1;
        end
      end else begin
        sq   <= {sq[SQ_W-2:0], 1'b0} + (mult[COORD_W-1] ? SQ_W'(mag) : SQ_W'(0));
        mult <= {mult[COORD_W-2:0], 1'b0};
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/touch_calibrate_debounce_filter.sv =====
// touch sample filter: linear calibration, press/release debounce, drag threshold
//
// Input stream s_*: one request per raw touch sample, taken when s_tvalid and
// s_tready are both high. Output stream m_*: exactly one filtered point per
// request, in order. The APB port writes and reads the eight setup registers
// (byte address 4*i); write them only while no request is in flight.
// From request to m_tvalid, the work is a shift-add multiply and a
// restoring division in the two axis units (both axes at once), then the
// two serial squarers for the drag distance, plus sequencing through the
// IDLE, MAP, SQ and OUT states. s_tready is high only between requests, so
// one sample is in work at a time.
// The result sits in an output register; the next request is taken while it
// waits, and if m_tready stays low the finished point waits in the final step
// and no further request is taken until the output register frees.
// rst clears the setup registers, the held point and the debounce candidate.
`include "touch_calibrate_debounce_filter_assert.svh"

module touch_calibrate_debounce_filter
  import tcdf_pkg::*;
#(
  parameter int unsigned PRESS_DEBOUNCE_MS   = 30,
  parameter int unsigned RELEASE_DEBOUNCE_MS = 50
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // raw_x [15:0], raw_y [31:16], sample_time_ms [63:32]
  input  logic        s_tuser,   // raw_pressed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // touch_x [15:0], touch_y [31:16], touch_time_ms [63:32]
  output logic        m_tuser,   // touch_pressed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAP,
    S_SQ,
    S_OUT
  } state_t;

  state_t state;

  logic [TOP_W-1:0]   scr_width;
  logic [TOP_W-1:0]   scr_height;
  logic [COORD_W-1:0] raw_x_min;
  logic [COORD_W-1:0] raw_x_max;
  logic [COORD_W-1:0] raw_y_min;
  logic [COORD_W-1:0] raw_y_max;
  logic [2:0]         orientation_flags;
  logic [31:0]        drag_threshold_sq;

  logic               in_pressed;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [TIME_W-1:0]  in_time;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic               start_map;
  logic               start_sq;
  logic               move_ge;

  logic               held_pressed;
  logic [COORD_W-1:0] held_x;
  logic [COORD_W-1:0] held_y;
  logic [TIME_W-1:0]  held_time;
  logic               pending_valid;
  logic               pending_pressed;
  logic [TIME_W-1:0]  pending_since;

  logic               held_pressed_next;
  logic [COORD_W-1:0] held_x_next;
  logic [COORD_W-1:0] held_y_next;
  logic [TIME_W-1:0]  held_time_next;
  logic               pending_valid_next;
  logic               pending_pressed_next;
  logic [TIME_W-1:0]  pending_since_next;

  logic               cfg_wr;
  reg_idx_t           reg_idx;
  logic               cal_valid;
  logic [TOP_W-1:0]   mx;
  logic [TOP_W-1:0]   my;
  axis_cfg_t          x_cfg;
  axis_cfg_t          y_cfg;
  logic               x_done;
  logic               y_done;
  logic [TOP_W-1:0]   x_map;
  logic [TOP_W-1:0]   y_map;
  logic [TOP_W-1:0]   x_inv;
  logic [TOP_W-1:0]   y_inv;
  logic [TOP_W-1:0]   x_cal;
  logic [TOP_W-1:0]   y_cal;
  logic [COORD_W:0]   dx;
  logic [COORD_W:0]   dy;
  logic               sq_x_done;
  logic               sq_y_done;
  logic [SQ_W-1:0]    sq_x;
  logic [SQ_W-1:0]    sq_y;
  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  debounce;
  logic               out_free;

  // setup registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_width         <= '0;
      scr_height        <= '0;
      raw_x_min         <= '0;
      raw_x_max         <= '0;
      raw_y_min         <= '0;
      raw_y_max         <= '0;
      orientation_flags <= '0;
      drag_threshold_sq <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DISPLAY_WIDTH:  scr_width         <= pwdata[TOP_W-1:0];
        REG_DISPLAY_HEIGHT: scr_height        <= pwdata[TOP_W-1:0];
        REG_RAW_X_MIN:      raw_x_min         <= pwdata[COORD_W-1:0];
        REG_RAW_X_MAX:      raw_x_max         <= pwdata[COORD_W-1:0];
        REG_RAW_Y_MIN:      raw_y_min         <= pwdata[COORD_W-1:0];
        REG_RAW_Y_MAX:      raw_y_max         <= pwdata[COORD_W-1:0];
        REG_ORIENTATION:    orientation_flags <= pwdata[2:0];
        REG_DRAG_THRESHOLD: drag_threshold_sq <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DISPLAY_WIDTH:  prdata = 32'(scr_width);
      REG_DISPLAY_HEIGHT: prdata = 32'(scr_height);
      REG_RAW_X_MIN:      prdata = 32'(raw_x_min);
      REG_RAW_X_MAX:      prdata = 32'(raw_x_max);
      REG_RAW_Y_MIN:      prdata = 32'(raw_y_min);
      REG_RAW_Y_MAX:      prdata = 32'(raw_y_max);
      REG_ORIENTATION:    prdata = 32'(orientation_flags);
      REG_DRAG_THRESHOLD: prdata = drag_threshold_sq;
    endcase
  end

  // calibration datapath
  assign cal_valid = (scr_width != '0) && (scr_height != '0) &&
                     (raw_x_max != raw_x_min) && (raw_y_max != raw_y_min);
  assign mx    = scr_width - 1'b1;
  assign my    = scr_height - 1'b1;
  assign x_cfg = '{lo: raw_x_min, hi: raw_x_max, top: mx};
  assign y_cfg = '{lo: raw_y_min, hi: raw_y_max, top: my};

  tcdf_axis u_axis_x (
    .clk   (clk),
    .rst   (rst),
    .start (start_map),
    .raw   (in_x),
    .cfg   (x_cfg),
    .done  (x_done),
    .value (x_map)
  );

  tcdf_axis u_axis_y (
    .clk   (clk),
    .rst   (rst),
    .start (start_map),
    .raw   (in_y),
    .cfg   (y_cfg),
    .done  (y_done),
    .value (y_map)
  );

  always_comb begin
    x_inv = orientation_flags[0] ? mx - x_map : x_map;
    y_inv = orientation_flags[1] ? my - y_map : y_map;
    // swap re-clamps each value to the range of the axis it lands on
    if (orientation_flags[2]) begin
      x_cal = (y_inv > mx) ? mx : y_inv;
      y_cal = (x_inv > my) ? my : x_inv;
    end else begin
      x_cal = x_inv;
      y_cal = y_inv;
    end
  end

  // drag distance
  assign dx = {cur_x[COORD_W-1], cur_x} - {held_x[COORD_W-1], held_x};
  assign dy = {cur_y[COORD_W-1], cur_y} - {held_y[COORD_W-1], held_y};

  tcdf_sq u_sq_x (
    .clk   (clk),
    .rst   (rst),
    .start (start_sq),
    .diff  (dx),
    .done  (sq_x_done),
    .sq    (sq_x)
  );

  tcdf_sq u_sq_y (
    .clk   (clk),
    .rst   (rst),
    .start (start_sq),
    .diff  (dy),
    .done  (sq_y_done),
    .sq    (sq_y)
  );

  // debounce and drag decision
  assign elapsed  = in_time - pending_since;
  assign debounce = in_pressed ? TIME_W'(PRESS_DEBOUNCE_MS) : TIME_W'(RELEASE_DEBOUNCE_MS);

  always_comb begin
    held_pressed_next    = held_pressed;
    held_x_next          = held_x;
    held_y_next          = held_y;
    held_time_next       = held_time;
    pending_valid_next   = pending_valid;
    pending_pressed_next = pending_pressed;
    pending_since_next   = pending_since;
    if (in_pressed != held_pressed) begin
      if (!pending_valid || (pending_pressed != in_pressed)) begin
        // new candidate restarts the debounce window
        pending_pressed_next = in_pressed;
        pending_since_next   = in_time;
        pending_valid_next   = 1'b1;
      end else if (elapsed >= debounce) begin
        held_pressed_next = in_pressed;
        if (in_pressed) begin
          held_x_next = cur_x;
          held_y_next = cur_y;
        end
        held_time_next     = in_time;
        pending_valid_next = 1'b0;
      end
    end else begin
      pending_valid_next = 1'b0;
      if (in_pressed && move_ge) begin
        held_x_next    = cur_x;
        held_y_next    = cur_y;
        held_time_next = in_time;
      end
    end
  end

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      start_map       <= 1'b0;
      start_sq        <= 1'b0;
      m_tvalid        <= 1'b0;
      held_pressed    <= 1'b0;
      held_x          <= '0;
      held_y          <= '0;
      held_time       <= '0;
      pending_valid   <= 1'b0;
      pending_pressed <= 1'b0;
      pending_since   <= '0;
    end else begin
      start_map <= (state == S_IDLE) && s_tvalid;
      start_sq  <= (state == S_MAP) && x_done;
      // a point taken in the cycle a new one loads leaves m_tvalid high
      if (m_tvalid && m_tready && !((state == S_OUT) && out_free)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_pressed <= s_tuser;
            in_x       <= s_tdata[15:0];
            in_y       <= s_tdata[31:16];
            in_time    <= s_tdata[63:32];
            state      <= S_MAP;
          end
        end
        S_MAP: begin
          if (x_done) begin
            // released samples and an unusable calibration pass raw values
            if (in_pressed && cal_valid) begin
              cur_x <= COORD_W'(x_cal);
              cur_y <= COORD_W'(y_cal);
            end else begin
              cur_x <= in_x;
              cur_y <= in_y;
            end
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_x_done) begin
            move_ge <= ({1'b0, sq_x} + {1'b0, sq_y}) >= (SQ_W + 1)'(drag_threshold_sq);
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            held_pressed    <= held_pressed_next;
            held_x          <= held_x_next;
            held_y          <= held_y_next;
            held_time       <= held_time_next;
            pending_valid   <= pending_valid_next;
            pending_pressed <= pending_pressed_next;
            pending_since   <= pending_since_next;
            m_tvalid        <= 1'b1;
            m_tuser         <= held_pressed_next;
            m_tdata         <= {held_time_next, held_y_next, held_x_next};
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TCDF_ASSERT(a_busy_after_take, (s_tvalid && s_tready) |=> !s_tready, "request taken while busy")
  `TCDF_ASSERT(a_axis_lockstep, x_done == y_done, "axis units out of step")
  `TCDF_ASSERT(a_sq_lockstep, sq_x_done == sq_y_done, "squarers out of step")
  `TCDF_ASSERT(a_pending_differs, pending_valid |-> (pending_pressed != held_pressed), "stale debounce candidate")
  `TCDF_ASSERT_NEVER(a_sq_stray, sq_x_done && (state != S_SQ), "squarer finished outside drag step")
  `TCDF_ASSERT(a_out_from_final, $rose(m_tvalid) |-> $past(state == S_OUT), "result loaded outside final step")

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the touch calibration and debounce filter
module tb;
  import tcdf_pkg::*;

  localparam int unsigned PRESS_MS     = 30;
  localparam int unsigned RELEASE_MS   = 50;
  localparam int          N_PHASES     = 8;
  localparam int          PHASE_ITEMS  = 160;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          STALL_LIMIT  = 5000;
  localparam int          SETTLE       = 100;

  typedef struct packed {
    logic        pressed;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] t;
  } sample_t;

  typedef struct packed {
    logic        pressed;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] t;
  } point_t;

  // a register write or a sample, with the point typed in where it is obvious
  typedef struct packed {
    bit       cfg;
    reg_idx_t sel;
    logic [31:0] value;
    sample_t  smp;
    bit       typed;
    point_t   want;
  } row_t;

  localparam row_t DIRECTED [25] = '{
    // reset setup: raw coordinates pass through
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b0, 16'h0, 16'h0, 32'd0},
      1'b1, '{1'b0, 16'h0, 16'h0, 32'd0}},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b1, 16'h8000, 16'h7fff, 32'd100},
      1'b1, '{1'b0, 16'h0, 16'h0, 32'd0}},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b1, 16'h7fff, 16'h8000, 32'd129},
      1'b1, '{1'b0, 16'h0, 16'h0, 32'd0}},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b1, 16'h7fff, 16'h8000, 32'd130},
      1'b1, '{1'b1, 16'h7fff, 16'h8000, 32'd130}},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b1, 16'h0, 16'h0, 32'd131},
      1'b1, '{1'b1, 16'h0, 16'h0, 32'd131}},
    // release candidate straddles the timestamp wrap
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b0, 16'hffff, 16'hffff, 32'hffff_fff0},
      1'b1, '{1'b1, 16'h0, 16'h0, 32'd131}},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b0, 16'h1234, 16'h5678, 32'h22},
      1'b1, '{1'b0, 16'h0, 16'h0, 32'h22}},
    // a brief press is dropped when the raw state returns to the held one
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b1, 16'h1, 16'h2, 32'd40},
      1'b1, '{1'b0, 16'h0, 16'h0, 32'h22}},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b0, 16'h3, 16'h4, 32'd41},
      1'b1, '{1'b0, 16'h0, 16'h0, 32'h22}},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b1, 16'h5, 16'h6, 32'd42},
      1'b1, '{1'b0, 16'h0, 16'h0, 32'h22}},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b1, 16'h5, 16'h6, 32'd71},
      1'b1, '{1'b0, 16'h0, 16'h0, 32'h22}},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b1, 16'h7, 16'h9, 32'd72},
      1'b1, '{1'b1, 16'h7, 16'h9, 32'd72}},
    // 4096 by 4096 screen, full raw span with y reversed, all orientation bits
    '{1'b1, REG_DISPLAY_WIDTH,  32'd4096,      '0, 1'b0, '0},
    '{1'b1, REG_DISPLAY_HEIGHT, 32'd4096,      '0, 1'b0, '0},
    '{1'b1, REG_RAW_X_MIN,      32'hffff_8000, '0, 1'b0, '0},
    '{1'b1, REG_RAW_X_MAX,      32'h0000_7fff, '0, 1'b0, '0},
    '{1'b1, REG_RAW_Y_MIN,      32'h0000_7fff, '0, 1'b0, '0},
    '{1'b1, REG_RAW_Y_MAX,      32'hffff_8000, '0, 1'b0, '0},
    '{1'b1, REG_ORIENTATION,    32'd7,         '0, 1'b0, '0},
    '{1'b1, REG_DRAG_THRESHOLD, 32'hffff_ffff, '0, 1'b0, '0},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b1, 16'h8000, 16'h8000, 32'd80}, 1'b0, '0},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b0, 16'h0, 16'h0, 32'd200}, 1'b0, '0},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b0, 16'h0, 16'h0, 32'd250}, 1'b0, '0},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b1, 16'h7fff, 16'h7fff, 32'd300}, 1'b0, '0},
    '{1'b0, REG_DISPLAY_WIDTH, '0, '{1'b1, 16'h8000, 16'h0, 32'd330}, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // raw_x [15:0], raw_y [31:16], sample_time_ms [63:32]
  logic        s_tuser = 1'b0; // raw_pressed
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // touch_x [15:0], touch_y [31:16], touch_time_ms [63:32]
  logic        m_tuser;        // touch_pressed
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // setup copy and filter state of the predictor
  logic [12:0]        cal_w = '0, cal_h = '0;
  logic signed [15:0] cal_x_lo = '0, cal_x_hi = '0, cal_y_lo = '0, cal_y_hi = '0;
  logic [2:0]         cal_orient = '0;
  logic [31:0]        cal_drag = '0;
  bit                 held_pressed = 1'b0;
  int                 held_x = 0, held_y = 0;
  logic [31:0]        held_t = '0;
  bit                 cand_valid = 1'b0, cand_pressed = 1'b0;
  logic [31:0]        cand_since = '0;

  point_t filtered_q[$];
  int     mismatches = 0;
  int     stall_cycles = 0;
  bit     idling = 1'b1;
  bit     hold_req = 1'b0;

  touch_calibrate_debounce_filter #(
    .PRESS_DEBOUNCE_MS  (PRESS_MS),
    .RELEASE_DEBOUNCE_MS(RELEASE_MS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_top(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // signed division truncates toward zero, as the block does
  function automatic int scale_axis(int raw, int lo, int hi, int top);
    longint num, den;
    num = (longint'(raw) - longint'(lo)) * longint'(top);
    den = longint'(hi) - longint'(lo);
    return int'(num / den);
  endfunction

  function automatic point_t filter_point(sample_t s);
    int                 x, y, mx, my, tmp;
    logic [31:0]        elapsed, hold_ms;
    longint             dx, dy;
    longint unsigned    dist_sq;
    point_t             r;
    x = int'($signed(s.x));
    y = int'($signed(s.y));
    if (s.pressed && cal_w != 0 && cal_h != 0 && cal_x_lo != cal_x_hi &&
        cal_y_lo != cal_y_hi) begin
      mx = int'(cal_w) - 1;
      my = int'(cal_h) - 1;
      x = clamp_top(scale_axis(x, cal_x_lo, cal_x_hi, mx), mx);
      y = clamp_top(scale_axis(y, cal_y_lo, cal_y_hi, my), my);
      if (cal_orient[0]) x = mx - x;
      if (cal_orient[1]) y = my - y;
      if (cal_orient[2]) begin
        tmp = x;
        x = clamp_top(y, mx);
        y = clamp_top(tmp, my);
      end
    end
    if (s.pressed != held_pressed) begin
      if (!cand_valid || cand_pressed != s.pressed) begin
        cand_pressed = s.pressed;
        cand_since = s.t;
        cand_valid = 1'b1;
      end else begin
        hold_ms = s.pressed ? PRESS_MS : RELEASE_MS;
        elapsed = s.t - cand_since;
        if (elapsed >= hold_ms) begin
          held_pressed = s.pressed;
          if (s.pressed) begin
            held_x = x;
            held_y = y;
          end
          held_t = s.t;
          cand_valid = 1'b0;
        end
      end
    end else begin
      cand_valid = 1'b0;
      if (s.pressed) begin
        dx = longint'(x) - longint'(held_x);
        dy = longint'(y) - longint'(held_y);
        dist_sq = dx * dx + dy * dy;
        if (dist_sq >= longint'(cal_drag)) begin
          held_x = x;
          held_y = y;
          held_t = s.t;
        end
      end
    end
    r.pressed = held_pressed;
    r.x = held_x[15:0];
    r.y = held_y[15:0];
    r.t = held_t;
    return r;
  endfunction

  // psel stays high between back-to-back transfers, the caller closes it
  task automatic apb_cycle(input bit wr, input reg_idx_t idx, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] mask;
    apb_cycle(1'b1, idx, value, readback);
    apb_cycle(1'b0, idx, '0, readback);
    mask = '1;
    case (idx)
      REG_DISPLAY_WIDTH: begin
        cal_w = value[12:0];
        mask = 32'h1fff;
      end
      REG_DISPLAY_HEIGHT: begin
        cal_h = value[12:0];
        mask = 32'h1fff;
      end
      REG_RAW_X_MIN: begin
        cal_x_lo = value[15:0];
        mask = 32'hffff;
      end
      REG_RAW_X_MAX: begin
        cal_x_hi = value[15:0];
        mask = 32'hffff;
      end
      REG_RAW_Y_MIN: begin
        cal_y_lo = value[15:0];
        mask = 32'hffff;
      end
      REG_RAW_Y_MAX: begin
        cal_y_hi = value[15:0];
        mask = 32'hffff;
      end
      REG_ORIENTATION: begin
        cal_orient = value[2:0];
        mask = 32'h7;
      end
      REG_DRAG_THRESHOLD: begin
        cal_drag = value;
      end
      default: ;
    endcase
    if ((readback & mask) !== (value & mask)) begin
      $error("%s: expected %0h, got %0h", idx.name(), value & mask, readback & mask);
      mismatches++;
    end
  endtask

  task automatic offer_sample(input sample_t smp, input bit typed, input point_t want);
    point_t predicted;
    // close any register transfer left open
    psel <= 1'b0;
    penable <= 1'b0;
    s_tvalid <= 1'b1;
    s_tuser <= smp.pressed;
    s_tdata <= {smp.t, smp.y, smp.x};
    do @(posedge clk); while (!s_tready);
    predicted = filter_point(smp);
    filtered_q.push_back(typed ? want : predicted);
  endtask

  task automatic sender_gap();
    if (idling && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_points();
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the block fills up and stalls its input
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    point_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[63:32]};
      if (filtered_q.size() == 0) begin
        $error("touch point with no request waiting: %0h", got);
        mismatches++;
      end else begin
        want = filtered_q.pop_front();
        if (got.pressed !== want.pressed) begin
          $error("touch_pressed: expected %0d, got %0d", want.pressed, got.pressed);
          mismatches++;
        end
        if (got.x !== want.x) begin
          $error("touch_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
          mismatches++;
        end
        if (got.y !== want.y) begin
          $error("touch_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
          mismatches++;
        end
        if (got.t !== want.t) begin
          $error("touch_time_ms: expected %0d, got %0d", want.t, got.t);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("touch_calibrate_debounce_filter test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] setting [8];
    sample_t     smp;
    logic [31:0] cur_t;
    bit          cur_p;
    int          rx_min, rx_max, ry_min, ry_max, lo, hi, tmp;
    int          cur_x, cur_y, run_left, roll;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg) begin
        s_tvalid <= 1'b0;
        drain_points();
        write_reg(DIRECTED[i].sel, DIRECTED[i].value);
      end else begin
        offer_sample(DIRECTED[i].smp, DIRECTED[i].typed, DIRECTED[i].want);
        sender_gap();
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      lo = $urandom_range(0, 4000);
      hi = lo + int'($urandom_range(1, 28000));
      if ($urandom_range(0, 3) == 0) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
      setting[REG_RAW_X_MIN] = lo;
      setting[REG_RAW_X_MAX] = hi;
      lo = $urandom_range(0, 4000);
      hi = lo + int'($urandom_range(1, 28000));
      if ($urandom_range(0, 3) == 0) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
      setting[REG_RAW_Y_MIN] = lo;
      setting[REG_RAW_Y_MAX] = hi;
      setting[REG_DISPLAY_WIDTH] = $urandom_range(1, 4096);
      setting[REG_DISPLAY_HEIGHT] = $urandom_range(1, 4096);
      setting[REG_ORIENTATION] = $urandom_range(0, 7);
      setting[REG_DRAG_THRESHOLD] = ($urandom_range(0, 7) == 0) ? $urandom
                                                                 : $urandom_range(0, 400);
      case (ph)
        0: begin
          setting[REG_DISPLAY_WIDTH] = 4096;
          setting[REG_DISPLAY_HEIGHT] = 4096;
          setting[REG_RAW_X_MIN] = 32'hffff_8000;
          setting[REG_RAW_X_MAX] = 32'h0000_7fff;
          setting[REG_RAW_Y_MIN] = 32'hffff_8000;
          setting[REG_RAW_Y_MAX] = 32'h0000_7fff;
          setting[REG_ORIENTATION] = 0;
          setting[REG_DRAG_THRESHOLD] = 0;
        end
        1: begin
          setting[REG_DISPLAY_WIDTH] = 1;
          setting[REG_DISPLAY_HEIGHT] = 1;
          setting[REG_ORIENTATION] = 7;
          setting[REG_DRAG_THRESHOLD] = 32'hffff_ffff;
        end
        2: setting[REG_DISPLAY_WIDTH] = 0;
        3: setting[REG_RAW_X_MAX] = setting[REG_RAW_X_MIN];
        default: ;
      endcase

      s_tvalid <= 1'b0;
      drain_points();
      for (int r = 0; r < 8; r++) write_reg(reg_idx_t'(r), setting[r]);

      lo = int'($signed(setting[REG_RAW_X_MIN][15:0]));
      hi = int'($signed(setting[REG_RAW_X_MAX][15:0]));
      rx_min = (lo < hi) ? lo : hi;
      rx_max = (lo < hi) ? hi : lo;
      lo = int'($signed(setting[REG_RAW_Y_MIN][15:0]));
      hi = int'($signed(setting[REG_RAW_Y_MAX][15:0]));
      ry_min = (lo < hi) ? lo : hi;
      ry_max = (lo < hi) ? hi : lo;
      cur_x = rx_min;
      cur_y = ry_min;
      cur_t = $urandom;
      cur_p = 1'b0;
      run_left = 0;
      idling = (ph != N_PHASES - 1);
      if (ph == 5) hold_req = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          cur_p = !cur_p;
          run_left = $urandom_range(1, 25);
        end
        run_left--;
        roll = $urandom_range(0, 99);
        if (roll < 80) cur_t += $urandom_range(0, 25);
        else if (roll < 96) cur_t += $urandom_range(26, 90);
        else cur_t = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          cur_x += int'($urandom_range(0, 600)) - 300;
          cur_y += int'($urandom_range(0, 600)) - 300;
        end else if (roll < 92) begin
          // margin past the raw range reaches the clamps
          cur_x = rx_min - 500 + int'($urandom_range(0, rx_max - rx_min + 1000));
          cur_y = ry_min - 500 + int'($urandom_range(0, ry_max - ry_min + 1000));
        end else begin
          cur_x = $urandom_range(0, 65535) - 32768;
          cur_y = $urandom_range(0, 65535) - 32768;
        end
        smp.pressed = ($urandom_range(0, 19) == 0) ? !cur_p : cur_p;
        smp.x = cur_x[15:0];
        smp.y = cur_y[15:0];
        smp.t = cur_t;
        cur_x = int'($signed(smp.x));
        cur_y = int'($signed(smp.y));
        offer_sample(smp, 1'b0, '0);
        sender_gap();
      end
    end

    s_tvalid <= 1'b0;
    drain_points();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("touch_calibrate_debounce_filter test passed");
    end else begin
      $display("touch_calibrate_debounce_filter test failed");
    end
    $finish;
  end

endmodule
